>>> rtl/core/rledc_pkg.sv
// Shared types, constants and BCD helper functions for the run-length
// encoder with decimal counts.
// No dependencies; every other file in rtl/core imports this package.
package rledc_pkg;

   // Number of BCD digits in a run count, and the string length limit.
   localparam int COUNT_DIGITS   = 6;
   localparam int MAX_STRING_LEN = 524287;

   // Field and counter widths.
   localparam int BYTE_W    = 8;
   localparam int BCD_W     = COUNT_DIGITS * 4;
   localparam int DIG_IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
   localparam int IN_LEN_W  = 20;
   localparam int ENC_LEN_W = 21;

   // Saturation limits of the length counters.
   localparam logic [IN_LEN_W-1:0]  IN_LEN_MAX  = IN_LEN_W'(MAX_STRING_LEN);
   localparam logic [ENC_LEN_W-1:0] ENC_LEN_MAX = ENC_LEN_W'(2 * MAX_STRING_LEN);

   // ASCII codes used when printing a count.
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
   localparam logic [BYTE_W-1:0] ASCII_ONE  = 8'd49;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [BCD_W-1:0]     bcd_type;
   typedef logic [DIG_IDX_W-1:0] dig_idx_type;
   typedef logic [IN_LEN_W-1:0]  in_len_type;
   typedef logic [ENC_LEN_W-1:0] enc_len_type;

   // BCD count of one.
   localparam bcd_type BCD_ONE = BCD_W'(1);

   // One finished run to print, optionally followed by a single-byte run.
   // Every command closes the results of the input beat that made it.
   typedef struct packed {
      byte_type    run_byte;
      bcd_type     count;
      dig_idx_type top;
      logic        tail_valid;
      byte_type    tail_byte;
      logic        done;
      in_len_type  input_len;
   } cmd_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Printing phases of the back end.
   typedef enum logic [1:0] {
      BK_DIGIT,
      BK_RUN,
      BK_TAIL_ONE,
      BK_TAIL_BYTE
   } back_state_type;

   // Add one to a BCD count; an all-nines count stays where it is.
   function automatic bcd_type bcd_inc(bcd_type v);
      bcd_type r;
      logic    carry;
      logic    nines;
      r     = v;
      carry = 1'b1;
      nines = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (v[i*4 +: 4] != 4'd9) begin
            nines = 1'b0;
         end
      end
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (carry) begin
            if (v[i*4 +: 4] == 4'd9) begin
               r[i*4 +: 4] = 4'd0;
            end else begin
               r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return nines ? v : r;
   endfunction

   // Index of the most significant nonzero digit (zero for a zero count).
   function automatic dig_idx_type bcd_top(bcd_type v);
      dig_idx_type t;
      t = '0;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (v[i*4 +: 4] != 4'd0) begin
            t = dig_idx_type'(i);
         end
      end
      return t;
   endfunction

endpackage

>>> rtl/core/rledc_front.sv
// Front end: accepts input beats, tracks the open run and the string
// length, and writes one print command per run that closes.
// Depends on rledc_pkg.
module rledc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rledc_pkg::byte_type    req_in_byte,
   input  logic                   req_end_of_string,
   input  rledc_pkg::q_status_type q_status,
   output logic                   push,
   output rledc_pkg::cmd_type     push_cmd
);
   import rledc_pkg::*;

   logic       open_ff, open_in;
   byte_type   byte_ff, byte_in;
   bcd_type    bcd_ff, bcd_in;
   in_len_type len_ff, len_in;

   logic       accept;
   logic       differ;
   in_len_type len_next;
   bcd_type    bcd_plus;
   bcd_type    cmd_count;

   // A beat is taken whenever the queue has room for its command.
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   assign differ   = open_ff && (req_in_byte != byte_ff);
   assign len_next = (len_ff < IN_LEN_MAX) ? len_ff + 1'b1 : len_ff;
   assign bcd_plus = bcd_inc(bcd_ff);

   // A run closes on a new byte or at the end of the string.
   assign push      = accept && (differ || req_end_of_string);
   assign cmd_count = differ ? bcd_ff : (open_ff ? bcd_plus : BCD_ONE);

   always_comb begin
      push_cmd.run_byte   = differ ? byte_ff : req_in_byte;
      push_cmd.count      = cmd_count;
      push_cmd.top        = bcd_top(cmd_count);
      push_cmd.tail_valid = differ && req_end_of_string;
      push_cmd.tail_byte  = req_in_byte;
      push_cmd.done       = req_end_of_string;
      push_cmd.input_len  = len_next;
   end

   // Run state update; the end of a string returns everything to reset.
   always_comb begin
      open_in = open_ff;
      byte_in = byte_ff;
      bcd_in  = bcd_ff;
      len_in  = len_ff;
      if (accept) begin
         if (req_end_of_string) begin
            open_in = 1'b0;
            byte_in = '0;
            bcd_in  = '0;
            len_in  = '0;
         end else begin
            open_in = 1'b1;
            byte_in = req_in_byte;
            bcd_in  = (open_ff && !differ) ? bcd_plus : BCD_ONE;
            len_in  = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         byte_ff <= '0;
         bcd_ff  <= '0;
         len_ff  <= '0;
      end else begin
         open_ff <= open_in;
         byte_ff <= byte_in;
         bcd_ff  <= bcd_in;
         len_ff  <= len_in;
      end
   end

endmodule

>>> rtl/core/rledc_queue.sv
// Short command queue between the front and the back end.
// Depends on rledc_pkg.
module rledc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rledc_pkg::cmd_type      push_cmd,
   input  logic                    pop,
   output rledc_pkg::cmd_type      head,
   output rledc_pkg::q_status_type status
);
   import rledc_pkg::*;

   cmd_type                   q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = q_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/rledc_back.sv
// Back end: prints the command at the queue head one byte per cycle
// into the output register while rsp is not stalled, and keeps the
// encoded length of the string. Depends on rledc_pkg.
module rledc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rledc_pkg::cmd_type      head,
   input  rledc_pkg::q_status_type q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rledc_pkg::byte_type     rsp_out_byte,
   output logic                    rsp_last_of_item,
   output logic                    rsp_string_done,
   output logic                    rsp_encoded_shorter
);
   import rledc_pkg::*;

   back_state_type state_ff, state_in;
   dig_idx_type    emitted_ff, emitted_in;
   enc_len_type    enc_ff, enc_in;

   logic        valid_ff, valid_in;
   byte_type    byte_ff;
   logic        last_ff;
   logic        done_ff;
   logic        shorter_ff;

   logic        advance;
   logic        emit;
   logic        final_beat;
   dig_idx_type dig_idx;
   byte_type    out_byte;
   enc_len_type enc_next;

   // The output register moves when empty or when its beat is taken.
   assign advance = !valid_ff || !rsp_stall;
   assign emit    = advance && !q_status.empty;
   assign pop     = emit && final_beat;
   assign dig_idx = head.top - emitted_ff;

   // Next printing phase.
   always_comb begin
      state_in = state_ff;
      if (emit) begin
         case (state_ff)
            BK_DIGIT: begin
               if (emitted_ff == head.top) begin
                  state_in = BK_RUN;
               end
            end
            BK_RUN: begin
               state_in = head.tail_valid ? BK_TAIL_ONE : BK_DIGIT;
            end
            BK_TAIL_ONE: begin
               state_in = BK_TAIL_BYTE;
            end
            BK_TAIL_BYTE: begin
               state_in = BK_DIGIT;
            end
            default: begin
               state_in = BK_DIGIT;
            end
         endcase
      end
   end

   // Byte for the current phase and whether it ends the command.
   always_comb begin
      out_byte   = head.run_byte;
      final_beat = 1'b0;
      case (state_ff)
         BK_DIGIT: begin
            out_byte = ASCII_ZERO + BYTE_W'(head.count[dig_idx*4 +: 4]);
         end
         BK_RUN: begin
            out_byte   = head.run_byte;
            final_beat = !head.tail_valid;
         end
         BK_TAIL_ONE: begin
            out_byte = ASCII_ONE;
         end
         BK_TAIL_BYTE: begin
            out_byte   = head.tail_byte;
            final_beat = 1'b1;
         end
         default: begin
            out_byte = head.run_byte;
         end
      endcase
   end

   // Digit counter and saturating encoded length.
   assign enc_next = (enc_ff < ENC_LEN_MAX) ? enc_ff + 1'b1 : enc_ff;

   always_comb begin
      emitted_in = emitted_ff;
      enc_in     = enc_ff;
      if (emit) begin
         emitted_in = (state_ff == BK_DIGIT && emitted_ff != head.top) ?
                      emitted_ff + 1'b1 : '0;
         enc_in     = (final_beat && head.done) ? '0 : enc_next;
      end
   end

   assign valid_in = advance ? emit : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_DIGIT;
         emitted_ff <= '0;
         enc_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emitted_ff <= emitted_in;
         enc_ff     <= enc_in;
         valid_ff   <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff    <= out_byte;
         last_ff    <= final_beat;
         done_ff    <= final_beat && head.done;
         shorter_ff <= final_beat && head.done &&
                       (enc_next < ENC_LEN_W'(head.input_len));
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_last_of_item    = last_ff;
   assign rsp_string_done     = done_ff;
   assign rsp_encoded_shorter = shorter_ff;

endmodule

>>> rtl/core/run_length_encoder_decimal_counts.sv
// Top level of the run-length encoder with decimal counts.
// Depends on rledc_pkg, rledc_front, rledc_queue and rledc_back.
//
// Usage:
// The req channel takes one byte of a string per beat; req_end_of_string
// marks the final byte. The rsp channel gives one encoded byte per beat:
// for each run, its length as ASCII decimal digits (most significant first,
// no leading zeros), then the run's byte. rsp_last_of_item marks the last
// beat caused by an input byte, rsp_string_done the last beat of a string,
// and with it rsp_encoded_shorter tells whether the encoding is shorter
// than the input. A byte that extends a run, and is not final, gives no beat.
// The first result of a byte passes through the command queue and the
// output register before it appears on rsp. The output register sends
// one byte per cycle while rsp is not stalled; in a string of single-byte
// runs each input byte gives two result bytes, a count digit and the byte.
// The front accepts a byte whenever the two-entry command queue has room.
// Reset (synchronous, active high) empties the queue and clears the run
// state. A stall on rsp holds the output beat; the queue absorbs commands
// until it fills, after which req_stall rises.
module run_length_encoder_decimal_counts (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rledc_pkg::byte_type req_in_byte,
   input  logic                req_end_of_string,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rledc_pkg::byte_type rsp_out_byte,
   output logic                rsp_last_of_item,
   output logic                rsp_string_done,
   output logic                rsp_encoded_shorter
);
   import rledc_pkg::*;

   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      head;

   // Input side: run tracking and command generation.
   rledc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // Command queue.
   rledc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Output side: printing of counts and run bytes.
   rledc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_status            (q_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_item    (rsp_last_of_item),
      .rsp_string_done     (rsp_string_done),
      .rsp_encoded_shorter (rsp_encoded_shorter)
   );

endmodule

>>> sim/rledc_encoding_checker.sv
// Checker for the run-length encoder with decimal counts: watches both channels,
// predicts the encoded beats of every accepted input byte and compares them.
// Depends on rledc_pkg for the field types and the length limits.
`timescale 1ns / 1ps

module rledc_encoding_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  rledc_pkg::byte_type req_in_byte,
   input  logic                req_end_of_string,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rledc_pkg::byte_type rsp_out_byte,
   input  logic                rsp_last_of_item,
   input  logic                rsp_string_done,
   input  logic                rsp_encoded_shorter,
   output int                  fail_count,
   output int                  pending
);
   import rledc_pkg::*;

   // Largest run length that fits the decimal count field.
   localparam int COUNT_MAX = 10 ** COUNT_DIGITS - 1;

   typedef struct packed {
      byte_type data;
      logic     last;
      logic     done;
      logic     shorter;
   } beat_type;

   beat_type expected_beats[$];
   beat_type item_beats[$];

   // Encoder state as the predictor sees it.
   byte_type    run_byte;
   int          run_len;
   logic        run_open;
   in_len_type  in_len;
   enc_len_type enc_len;
   int          mismatches = 0;

   task automatic clear_string();
      run_byte = '0;
      run_len  = 0;
      run_open = 1'b0;
      in_len   = '0;
      enc_len  = '0;
   endtask

   // One encoded byte; the encoded length stops at its limit.
   task automatic emit_byte(input byte_type value);
      item_beats.push_back('{data: value, last: 1'b0, done: 1'b0, shorter: 1'b0});
      if (enc_len < ENC_LEN_MAX) begin
         enc_len = enc_len + 1'b1;
      end
   endtask

   // A closed run prints as its decimal length followed by its byte.
   task automatic emit_run();
      string digits;
      digits = $sformatf("%0d", run_len);
      for (int i = 0; i < digits.len(); i++) begin
         emit_byte(byte_type'(digits[i]));
      end
      emit_byte(run_byte);
   endtask

   // Work out every beat that one input byte causes and queue them in order.
   task automatic predict_encoding(input byte_type b, input logic eos);
      beat_type tail;
      item_beats.delete();
      if (in_len < IN_LEN_MAX) begin
         in_len = in_len + 1'b1;
      end
      if (!run_open) begin
         run_byte = b;
         run_len  = 1;
         run_open = 1'b1;
      end else if (b == run_byte) begin
         if (run_len < COUNT_MAX) begin
            run_len++;
         end
      end else begin
         emit_run();
         run_byte = b;
         run_len  = 1;
      end
      // The end mark flushes the open run and carries the length verdict.
      if (eos) begin
         emit_run();
         tail         = item_beats[item_beats.size() - 1];
         tail.done    = 1'b1;
         tail.shorter = (enc_len < in_len);
         item_beats[item_beats.size() - 1] = tail;
         clear_string();
      end
      if (item_beats.size() > 0) begin
         tail      = item_beats[item_beats.size() - 1];
         tail.last = 1'b1;
         item_beats[item_beats.size() - 1] = tail;
      end
      foreach (item_beats[i]) begin
         expected_beats.push_back(item_beats[i]);
      end
   endtask

   task automatic flag_mismatch(input string what, input beat_type want,
                                input beat_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display({"%0t ns: %s: expected byte %h last %b done %b shorter %b, ",
                   "got byte %h last %b done %b shorter %b"},
                  $time, what, want.data, want.last, want.done, want.shorter,
                  got.data, got.last, got.done, got.shorter);
      end
   endtask

   // Compare the result beat first, then predict from the input beat.
   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (reset) begin
         expected_beats.delete();
         clear_string();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{data: rsp_out_byte, last: rsp_last_of_item, done: rsp_string_done,
                    shorter: rsp_encoded_shorter};
            if (expected_beats.size() == 0) begin
               flag_mismatch("result beat with nothing expected", '0, got);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  flag_mismatch("result beat differs", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_encoding(req_in_byte, req_end_of_string);
         end
      end
      pending    = expected_beats.size();
      fail_count = mismatches;
   end

endmodule

>>> sim/tb_run_length_encoder_decimal_counts.sv
// Testbench top for the run-length encoder with decimal counts: drives strings
// with random gaps and stalls, and gives the verdict from rledc_encoding_checker.
// Depends on rledc_pkg, the encoder RTL and sim/rledc_encoding_checker.sv.
`timescale 1ns / 1ps

module tb_run_length_encoder_decimal_counts;
   import rledc_pkg::*;

   localparam int RANDOM_ITEMS   = 450;
   localparam int DRAIN_CYCLES   = 8;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   byte_type req_in_byte;
   logic     req_end_of_string;
   logic     rsp_valid;
   logic     rsp_stall;
   byte_type rsp_out_byte;
   logic     rsp_last_of_item;
   logic     rsp_string_done;
   logic     rsp_encoded_shorter;
   int       fail_count;
   int       pending;
   int       items_sent;

   run_length_encoder_decimal_counts uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .req_end_of_string   (req_end_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_item    (rsp_last_of_item),
      .rsp_string_done     (rsp_string_done),
      .rsp_encoded_shorter (rsp_encoded_shorter)
   );

   rledc_encoding_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .req_end_of_string   (req_end_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_item    (rsp_last_of_item),
      .rsp_string_done     (rsp_string_done),
      .rsp_encoded_shorter (rsp_encoded_shorter),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Give up long after the slowest correct run would have ended.
   initial begin
      #150_000_000;
      $display("tb_run_length_encoder_decimal_counts NOT OK");
      $finish;
   end

   // Receiver stalls in bursts: mostly short, a few long, and some calm stretches.
   initial begin
      int burst;
      int r;
      rsp_stall = 1'b0;
      burst     = 0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rsp_stall <= 1'b0;
               burst = $urandom_range(0, 7);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               burst = $urandom_range(0, 2);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               burst = $urandom_range(9, 39);
            end else begin
               rsp_stall <= 1'b0;
               burst = $urandom_range(99, 299);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Mostly short runs; some cross into two digits, a few reach about a hundred.
   function automatic int pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end else if (r < 93) begin
         return $urandom_range(4, 12);
      end else if (r < 99) begin
         return $urandom_range(13, 40);
      end
      return $urandom_range(95, 105);
   endfunction

   // Present one byte after an optional gap and hold it until the beat is taken.
   // Called and returning at a falling edge.
   task automatic send_byte(input byte_type b, input logic eos, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Stop sending until every expected beat has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // A string of random runs; a small alphabet now and then merges neighbors.
   task automatic send_random_string();
      int       n_runs;
      int       run_len;
      logic     calm;
      byte_type b;
      n_runs = $urandom_range(1, 8);
      calm   = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < n_runs; r++) begin
         run_len = pick_run_length();
         if ($urandom_range(0, 2) == 0) begin
            b = byte_type'($urandom_range(65, 68));
         end else begin
            b = byte_type'($urandom);
         end
         for (int i = 0; i < run_len; i++) begin
            send_byte(b, (r == n_runs - 1) && (i == run_len - 1), calm ? 0 : pick_gap());
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_in_byte       = '0;
      req_end_of_string = 1'b0;
      items_sent        = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-byte strings at both ends of the byte range.
      send_byte(8'h00, 1'b1, 0);
      send_byte(8'hFF, 1'b1, 2);
      // The final byte closes the previous run, so both runs come out together.
      send_byte(8'h41, 1'b0, 0);
      send_byte(8'h41, 1'b0, 0);
      send_byte(8'h42, 1'b1, 0);
      // A run of ten prints a zero digit inside its count.
      for (int i = 0; i < 10; i++) begin
         send_byte(8'h55, 1'b0, 0);
      end
      send_byte(8'hAA, 1'b1, 1);
      // The end mark lands on a byte that continues the run.
      send_byte(8'h0F, 1'b0, 0);
      send_byte(8'hF0, 1'b0, 3);
      send_byte(8'hF0, 1'b1, 0);
      wait_drain();

      // Random strings.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         send_random_string();
      end
      wait_drain();

      if (fail_count == 0 && pending == 0) begin
         $display("tb_run_length_encoder_decimal_counts OK");
      end else begin
         $display("tb_run_length_encoder_decimal_counts NOT OK");
      end
      $finish;
   end

endmodule
